### design/kfi_pkg.sv
package kfi_pkg;

    localparam int TIME_W = 24;
    localparam int VAL_W  = 24;
    localparam int ELAP_W = 16;
    localparam int FUNC_W = 3;
    localparam int STAT_W = 2;
    localparam int PROD_W = 2 * VAL_W;
    localparam int STEP_W = 6;

    localparam logic signed [VAL_W-1:0] ONE_Q816 = 24'sh010000;
    localparam logic signed [VAL_W-1:0] VAL_MAX  = 24'sh7FFFFF;
    localparam logic signed [VAL_W-1:0] VAL_MIN  = 24'sh800000;
    localparam logic [TIME_W-1:0]       TIME_MAX = 24'hFFFFFF;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_TICK    = 3'd0,
        FUNC_INSERT  = 3'd1,
        FUNC_REMOVE  = 3'd2,
        FUNC_FIND    = 3'd3,
        FUNC_RESTART = 3'd4
    } func_t;

    typedef enum logic [STAT_W-1:0] {
        STAT_OK        = 2'd0,
        STAT_FULL      = 2'd1,
        STAT_NOT_FOUND = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_TICK_A,
        S_TICK_B,
        S_LERP,
        S_OUT
    } kfi_state_t;

    typedef enum logic [1:0] {
        L_IDLE,
        L_MUL,
        L_DIV,
        L_FIN
    } lerp_state_t;

    typedef struct packed {
        logic [TIME_W-1:0]       t_ms;
        logic signed [VAL_W-1:0] x;
        logic signed [VAL_W-1:0] y;
        logic signed [VAL_W-1:0] z;
    } key_t;

    typedef struct packed {
        key_t key;
        logic gt;
        logic hit_before;
    } sel_t;

    typedef struct packed {
        logic signed [VAL_W-1:0] v0;
        logic [VAL_W-1:0]        dmag;
        logic [TIME_W-1:0]       offm;
        logic                    neg;
        logic [TIME_W-1:0]       dt;
    } lerp_req_t;

    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic [ELAP_W-1:0] elapsed_ms;
        key_t              key;
    } item_t;

    typedef struct packed {
        logic signed [VAL_W-1:0] x;
        logic signed [VAL_W-1:0] y;
        logic signed [VAL_W-1:0] z;
        logic [STAT_W-1:0]       status;
    } res_t;

    function automatic lerp_req_t make_req(
        input logic signed [VAL_W-1:0] v0,
        input logic signed [VAL_W-1:0] v1,
        input logic [TIME_W-1:0]       offm,
        input logic                    off_neg,
        input logic [TIME_W-1:0]       dt
    );
        lerp_req_t r;
        logic [VAL_W:0] d;
        logic [VAL_W:0] dn;
        d  = {v1[VAL_W-1], v1} - {v0[VAL_W-1], v0};
        dn = -d;
        r.v0   = v0;
        r.dmag = d[VAL_W] ? dn[VAL_W-1:0] : d[VAL_W-1:0];
        r.offm = offm;
        r.neg  = d[VAL_W] ^ off_neg;
        r.dt   = dt;
        return r;
    endfunction

endpackage

### design/kfi_req_if.sv
interface kfi_req_if;
    logic        valid;
    logic        ready;
    logic [2:0]  func;
    logic [15:0] elapsed_ms;
    logic [23:0] key_time;
    logic signed [23:0] key_x;
    logic signed [23:0] key_y;
    logic signed [23:0] key_z;

    modport source (output valid, func, elapsed_ms, key_time, key_x, key_y, key_z,
                    input ready);
    modport sink (input valid, func, elapsed_ms, key_time, key_x, key_y, key_z,
                  output ready);
endinterface

### design/kfi_rsp_if.sv
interface kfi_rsp_if;
    logic        valid;
    logic        ready;
    logic signed [23:0] value_x;
    logic signed [23:0] value_y;
    logic signed [23:0] value_z;
    logic [1:0]  status;

    modport source (output valid, value_x, value_y, value_z, status, input ready);
    modport sink (input valid, value_x, value_y, value_z, status, output ready);
endinterface

### design/kfi_cell.sv
module kfi_cell #(
    parameter int IDX   = 0,
    parameter int IDX_W = 4,
    parameter int CNT_W = 5
) (
    input  logic               clk,
    input  logic               ins_en,
    input  logic               rem_en,
    input  kfi_pkg::key_t      new_key,
    input  logic [CNT_W-1:0]   count,
    input  logic [IDX_W-1:0]   addr_a,
    input  logic [IDX_W-1:0]   addr_b,
    input  kfi_pkg::key_t      left_key,
    input  kfi_pkg::key_t      right_key,
    input  logic               gt_in,
    input  logic               hit_in,
    input  kfi_pkg::sel_t      sel_a_in,
    input  kfi_pkg::sel_t      sel_b_in,
    output kfi_pkg::key_t      key,
    output logic               gt_out,
    output logic               hit_out,
    output kfi_pkg::sel_t      sel_a_out,
    output kfi_pkg::sel_t      sel_b_out
);
    import kfi_pkg::*;

    key_t key_reg;
    key_t key_next;
    sel_t own;
    logic valid;
    logic match;

    assign valid   = CNT_W'(IDX) < count;
    assign gt_out  = valid && (new_key.t_ms > key_reg.t_ms);
    assign match   = valid && (key_reg == new_key);
    assign hit_out = hit_in | match;
    assign key     = key_reg;

    always_comb
    begin
        own.key        = key_reg;
        own.gt         = gt_out;
        own.hit_before = hit_in;
        sel_a_out = (addr_a == IDX_W'(IDX)) ? own : sel_a_in;
        sel_b_out = (addr_b == IDX_W'(IDX)) ? own : sel_b_in;
    end

    always_comb
    begin
        key_next = key_reg;
        if (ins_en && (CNT_W'(IDX) <= count))
        begin
            if (!gt_in)
            begin
                key_next = left_key;
            end
            else if (!gt_out)
            begin
                key_next = new_key;
            end
        end
        if (rem_en && hit_out)
        begin
            key_next = right_key;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg <= key_next;
    end
endmodule

### design/kfi_lerp.sv
module kfi_lerp (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  kfi_pkg::lerp_req_t    req,
    output logic                  done,
    output logic signed [23:0]    value
);
    import kfi_pkg::*;

    lerp_state_t             state_reg, state_next;
    logic [STEP_W-1:0]       cnt_reg, cnt_next;
    logic [PROD_W-1:0]       acc_reg, acc_next;
    logic [PROD_W-1:0]       mcand_reg, mcand_next;
    logic [TIME_W-1:0]       mult_reg, mult_next;
    logic [TIME_W-1:0]       rem_reg, rem_next;
    logic signed [VAL_W-1:0] v0_reg, v0_next;
    logic                    neg_reg, neg_next;
    logic [TIME_W-1:0]       dt_reg, dt_next;
    logic [TIME_W:0]         rem_sh;
    logic [PROD_W+1:0]       q_ext;
    logic [PROD_W+1:0]       q_signed;
    logic signed [PROD_W+1:0] sum;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= L_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg   <= acc_next;
        mcand_reg <= mcand_next;
        mult_reg  <= mult_next;
        rem_reg   <= rem_next;
        v0_reg    <= v0_next;
        neg_reg   <= neg_next;
        dt_reg    <= dt_next;
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        acc_next   = acc_reg;
        mcand_next = mcand_reg;
        mult_next  = mult_reg;
        rem_next   = rem_reg;
        v0_next    = v0_reg;
        neg_next   = neg_reg;
        dt_next    = dt_reg;
        rem_sh     = {rem_reg, acc_reg[PROD_W-1]};
        unique case (state_reg)
            L_IDLE:
            begin
                if (start)
                begin
                    acc_next   = '0;
                    mcand_next = PROD_W'(req.dmag);
                    mult_next  = req.offm;
                    v0_next    = req.v0;
                    neg_next   = req.neg;
                    dt_next    = req.dt;
                    cnt_next   = '0;
                    state_next = L_MUL;
                end
            end
            L_MUL:
            begin
                if (mult_reg[0])
                begin
                    acc_next = acc_reg + mcand_reg;
                end
                mcand_next = {mcand_reg[PROD_W-2:0], 1'b0};
                mult_next  = {1'b0, mult_reg[TIME_W-1:1]};
                cnt_next   = cnt_reg + 1'b1;
                if (cnt_reg == STEP_W'(TIME_W - 1))
                begin
                    cnt_next   = '0;
                    rem_next   = '0;
                    state_next = L_DIV;
                end
            end
            L_DIV:
            begin
                if (rem_sh >= {1'b0, dt_reg})
                begin
                    rem_next = TIME_W'(rem_sh - {1'b0, dt_reg});
                    acc_next = {acc_reg[PROD_W-2:0], 1'b1};
                end
                else
                begin
                    rem_next = rem_sh[TIME_W-1:0];
                    acc_next = {acc_reg[PROD_W-2:0], 1'b0};
                end
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == STEP_W'(PROD_W - 1))
                begin
                    state_next = L_FIN;
                end
            end
            L_FIN:
            begin
                state_next = L_IDLE;
            end
            default:
            begin
                state_next = L_IDLE;
            end
        endcase
    end

    always_comb
    begin
        q_ext    = {2'b00, acc_reg};
        q_signed = neg_reg ? -q_ext : q_ext;
        sum      = signed'(q_signed) + signed'((PROD_W+2)'(v0_reg));
        if (sum > signed'((PROD_W+2)'(VAL_MAX)))
        begin
            value = VAL_MAX;
        end
        else if (sum < signed'((PROD_W+2)'(VAL_MIN)))
        begin
            value = VAL_MIN;
        end
        else
        begin
            value = sum[VAL_W-1:0];
        end
    end

    assign done = (state_reg == L_FIN);
endmodule

### design/keyframe_linear_interpolator.sv
// An interpolating tick passes through S_EXEC, S_TICK_A and S_TICK_B, a 24-step shift-add
// multiply and a 48-step restoring divide on all three axes at once, and S_OUT, which
// loads the result register. Insert, remove, find, restart and unused codes go from
// S_EXEC straight to S_OUT; a tick that needs no division goes through S_TICK_A, and
// S_TICK_B too when the two keys share a time. The input is ready again once the result
// register loads, and waits while that register still holds a result not yet taken.
// Reset clears the key count, index, elapsed total and the response valid, and returns to idle.
module keyframe_linear_interpolator #(
    parameter int MAX_KEYS = 16
) (
    input logic        clk,
    input logic        rst_n,
    kfi_req_if.sink    req,
    kfi_rsp_if.source  rsp
);
    import kfi_pkg::*;

    localparam int IDX_W = (MAX_KEYS > 1) ? $clog2(MAX_KEYS) : 1;
    localparam int CNT_W = $clog2(MAX_KEYS + 1);

    kfi_state_t         state_reg, state_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [IDX_W-1:0]   cur_reg, cur_next;
    logic [TIME_W-1:0]  total_reg, total_next;
    item_t              item_reg;
    res_t               pend_reg, pend_next;
    res_t               out_reg;
    logic               out_valid_reg;

    logic               ins_en, rem_en, lerp_start;
    logic [IDX_W-1:0]   addr_a, addr_b;
    logic [CNT_W-1:0]   last, cur_ext, cnt_dec, cur_tmp;
    logic [TIME_W:0]    total_sum;
    logic [TIME_W-1:0]  total_sat;
    logic [TIME_W:0]    off;
    logic [TIME_W:0]    off_n;
    logic [TIME_W-1:0]  offm, dt;
    lerp_req_t          req_x, req_y, req_z;
    logic               done_x, done_y, done_z;
    logic signed [VAL_W-1:0] lv_x, lv_y, lv_z;
    logic               slot_free;

    key_t               cell_key [MAX_KEYS];
    logic [MAX_KEYS:0]  gt_c, hit_c;
    sel_t               sel_a_c [MAX_KEYS+1];
    sel_t               sel_b_c [MAX_KEYS+1];

    assign gt_c[0]            = 1'b1;
    assign hit_c[0]           = 1'b0;
    assign sel_a_c[MAX_KEYS]  = '0;
    assign sel_b_c[MAX_KEYS]  = '0;

    for (genvar i = 0; i < MAX_KEYS; i++)
    begin : g_cell
        key_t left_k, right_k;
        if (i == 0)
        begin : g_first
            assign left_k = item_reg.key;
        end
        else
        begin : g_mid
            assign left_k = cell_key[i-1];
        end
        if (i == MAX_KEYS - 1)
        begin : g_last
            assign right_k = cell_key[i];
        end
        else
        begin : g_inner
            assign right_k = cell_key[i+1];
        end
        kfi_cell #(.IDX(i), .IDX_W(IDX_W), .CNT_W(CNT_W)) u_cell (
            .clk       (clk),
            .ins_en    (ins_en),
            .rem_en    (rem_en),
            .new_key   (item_reg.key),
            .count     (count_reg),
            .addr_a    (addr_a),
            .addr_b    (addr_b),
            .left_key  (left_k),
            .right_key (right_k),
            .gt_in     (gt_c[i]),
            .hit_in    (hit_c[i]),
            .sel_a_in  (sel_a_c[i+1]),
            .sel_b_in  (sel_b_c[i+1]),
            .key       (cell_key[i]),
            .gt_out    (gt_c[i+1]),
            .hit_out   (hit_c[i+1]),
            .sel_a_out (sel_a_c[i]),
            .sel_b_out (sel_b_c[i])
        );
    end

    kfi_lerp u_lerp_x (.clk(clk), .rst_n(rst_n), .start(lerp_start), .req(req_x),
                       .done(done_x), .value(lv_x));
    kfi_lerp u_lerp_y (.clk(clk), .rst_n(rst_n), .start(lerp_start), .req(req_y),
                       .done(done_y), .value(lv_y));
    kfi_lerp u_lerp_z (.clk(clk), .rst_n(rst_n), .start(lerp_start), .req(req_z),
                       .done(done_z), .value(lv_z));

    assign last      = count_reg - 1'b1;
    assign cur_ext   = CNT_W'(cur_reg);
    assign addr_a    = (state_reg == S_TICK_A) ? IDX_W'(cur_reg + 1'b1) : cur_reg;
    assign addr_b    = (state_reg == S_TICK_A) ? last[IDX_W-1:0] : IDX_W'(cur_reg + 1'b1);
    assign total_sum = {1'b0, total_reg} + (TIME_W+1)'(item_reg.elapsed_ms);
    assign total_sat = total_sum[TIME_W] ? TIME_MAX : total_sum[TIME_W-1:0];
    assign cnt_dec   = count_reg - 1'b1;

    always_comb
    begin
        off   = {1'b0, total_reg} - {1'b0, sel_a_c[0].key.t_ms};
        off_n = -off;
        offm  = off[TIME_W] ? off_n[TIME_W-1:0] : off[TIME_W-1:0];
        dt    = sel_b_c[0].key.t_ms - sel_a_c[0].key.t_ms;
        req_x = make_req(sel_a_c[0].key.x, sel_b_c[0].key.x, offm, off[TIME_W], dt);
        req_y = make_req(sel_a_c[0].key.y, sel_b_c[0].key.y, offm, off[TIME_W], dt);
        req_z = make_req(sel_a_c[0].key.z, sel_b_c[0].key.z, offm, off[TIME_W], dt);
    end

    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        cur_next   = cur_reg;
        total_next = total_reg;
        pend_next  = pend_reg;
        ins_en     = 1'b0;
        rem_en     = 1'b0;
        lerp_start = 1'b0;
        cur_tmp    = cur_ext;
        unique case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                pend_next  = '0;
                state_next = S_OUT;
                case (item_reg.func)
                    FUNC_TICK:
                    begin
                        state_next = S_TICK_A;
                    end
                    FUNC_INSERT:
                    begin
                        if (count_reg == CNT_W'(MAX_KEYS))
                        begin
                            pend_next.status = STAT_FULL;
                        end
                        else
                        begin
                            ins_en     = 1'b1;
                            count_next = count_reg + 1'b1;
                            if (count_reg == '0)
                            begin
                                cur_next = '0;
                            end
                            else if (!sel_a_c[0].gt)
                            begin
                                cur_next = cur_reg + 1'b1;
                            end
                        end
                    end
                    FUNC_REMOVE:
                    begin
                        if (hit_c[MAX_KEYS])
                        begin
                            rem_en     = 1'b1;
                            count_next = cnt_dec;
                            if (sel_a_c[0].hit_before)
                            begin
                                cur_tmp = cur_ext - 1'b1;
                            end
                            if (cnt_dec == '0)
                            begin
                                cur_next = '0;
                            end
                            else if (cur_tmp >= cnt_dec)
                            begin
                                cur_next = IDX_W'(cnt_dec - 1'b1);
                            end
                            else
                            begin
                                cur_next = IDX_W'(cur_tmp);
                            end
                        end
                        else
                        begin
                            pend_next.status = STAT_NOT_FOUND;
                        end
                    end
                    FUNC_FIND:
                    begin
                        if (!hit_c[MAX_KEYS])
                        begin
                            pend_next.status = STAT_NOT_FOUND;
                        end
                    end
                    FUNC_RESTART:
                    begin
                        cur_next   = '0;
                        total_next = '0;
                    end
                    default:
                    begin
                    end
                endcase
            end
            S_TICK_A:
            begin
                state_next = S_OUT;
                if (count_reg == '0)
                begin
                    pend_next.x = ONE_Q816;
                    pend_next.y = ONE_Q816;
                    pend_next.z = ONE_Q816;
                end
                else if (cur_ext >= last)
                begin
                    cur_next    = last[IDX_W-1:0];
                    pend_next.x = sel_b_c[0].key.x;
                    pend_next.y = sel_b_c[0].key.y;
                    pend_next.z = sel_b_c[0].key.z;
                end
                else
                begin
                    total_next = total_sat;
                    state_next = S_TICK_B;
                    if (total_sat >= sel_a_c[0].key.t_ms)
                    begin
                        cur_next = cur_reg + 1'b1;
                        if (cur_ext + 1'b1 == last)
                        begin
                            pend_next.x = sel_b_c[0].key.x;
                            pend_next.y = sel_b_c[0].key.y;
                            pend_next.z = sel_b_c[0].key.z;
                            state_next  = S_OUT;
                        end
                    end
                end
            end
            S_TICK_B:
            begin
                if (sel_a_c[0].key.t_ms == sel_b_c[0].key.t_ms)
                begin
                    pend_next.x = sel_b_c[0].key.x;
                    pend_next.y = sel_b_c[0].key.y;
                    pend_next.z = sel_b_c[0].key.z;
                    state_next  = S_OUT;
                end
                else
                begin
                    lerp_start = 1'b1;
                    state_next = S_LERP;
                end
            end
            S_LERP:
            begin
                if (done_x && done_y && done_z)
                begin
                    pend_next.x = lv_x;
                    pend_next.y = lv_y;
                    pend_next.z = lv_z;
                    state_next  = S_OUT;
                end
            end
            S_OUT:
            begin
                if (slot_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign slot_free = !out_valid_reg || rsp.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            cur_reg       <= '0;
            total_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            cur_reg   <= cur_next;
            total_reg <= total_next;
            if (state_reg == S_OUT && slot_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        pend_reg <= pend_next;
        if (state_reg == S_IDLE && req.valid)
        begin
            item_reg.func       <= req.func;
            item_reg.elapsed_ms <= req.elapsed_ms;
            item_reg.key.t_ms   <= req.key_time;
            item_reg.key.x      <= req.key_x;
            item_reg.key.y      <= req.key_y;
            item_reg.key.z      <= req.key_z;
        end
        if (state_reg == S_OUT && slot_free)
        begin
            out_reg <= pend_reg;
        end
    end

    assign req.ready   = (state_reg == S_IDLE);
    assign rsp.valid   = out_valid_reg;
    assign rsp.value_x = out_reg.x;
    assign rsp.value_y = out_reg.y;
    assign rsp.value_z = out_reg.z;
    assign rsp.status  = out_reg.status;

`ifndef NO_ASSERTIONS
    a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(MAX_KEYS))
        else $error("Key count exceeds the table size.");
    a_cur_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg != '0) |-> (cur_ext < count_reg))
        else $error("Current index is beyond the last key.");
    a_cur_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == '0) |-> (cur_reg == '0))
        else $error("Current index is not zero on an empty table.");
    a_lerp_owned: assert property (@(posedge clk) disable iff (!rst_n)
        done_x |-> (state_reg == S_LERP))
        else $error("Interpolation finished outside the wait state.");
`endif
endmodule

### verif/keyframe_linear_interpolator_tb.sv
`timescale 1ns / 100ps

module keyframe_linear_interpolator_tb;
    import kfi_pkg::*;

    localparam int NUM_KEYS = 16;
    localparam int STALL_LIMIT = 20000;
    localparam int FUNC_UNUSED_LO = 5;
    localparam int FUNC_UNUSED_HI = 7;

    logic clk;
    logic rst_n;

    kfi_req_if req ();
    kfi_rsp_if rsp ();

    keyframe_linear_interpolator #(.MAX_KEYS(NUM_KEYS)) dut (
        .clk(clk),
        .rst_n(rst_n),
        .req(req.sink),
        .rsp(rsp.source)
    );

    logic [TIME_W-1:0]       mdl_time [NUM_KEYS];
    logic signed [VAL_W-1:0] mdl_x [NUM_KEYS];
    logic signed [VAL_W-1:0] mdl_y [NUM_KEYS];
    logic signed [VAL_W-1:0] mdl_z [NUM_KEYS];
    int unsigned             mdl_count;
    int unsigned             mdl_index;
    logic [TIME_W-1:0]       mdl_total;

    res_t expected_results [int];
    int   exp_head;
    int   exp_tail;
    int   error_count;
    int   send_idle_pct;
    int   recv_idle_pct;
    int   quiet_cycles;

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #4 clk = ~clk;
        end
    end

    function automatic logic signed [VAL_W-1:0] lerp_axis(
        input logic signed [VAL_W-1:0] v0,
        input logic signed [VAL_W-1:0] v1,
        input longint off,
        input longint dt
    );
        longint r;
        r = longint'(v0) + ((longint'(v1) - longint'(v0)) * off) / dt;
        if (r > 64'sd8388607)
        begin
            r = 64'sd8388607;
        end
        if (r < -64'sd8388608)
        begin
            r = -64'sd8388608;
        end
        return r[VAL_W-1:0];
    endfunction

    function automatic res_t key_value(input int unsigned i);
        res_t r;
        r.x = mdl_x[i];
        r.y = mdl_y[i];
        r.z = mdl_z[i];
        r.status = STAT_OK;
        return r;
    endfunction

    function automatic int find_pos(input item_t it);
        for (int i = 0; i < int'(mdl_count); i++)
        begin
            if (mdl_time[i] == it.key.t_ms && mdl_x[i] == it.key.x
                && mdl_y[i] == it.key.y && mdl_z[i] == it.key.z)
            begin
                return i;
            end
        end
        return -1;
    endfunction

    function automatic res_t predict_item(input item_t it);
        res_t r;
        int unsigned last;
        int unsigned p;
        int pos;
        longint sum;
        r = '0;
        case (it.func)
            FUNC_TICK:
            begin
                if (mdl_count == 0)
                begin
                    r.x = ONE_Q816;
                    r.y = ONE_Q816;
                    r.z = ONE_Q816;
                end
                else
                begin
                    last = mdl_count - 1;
                    if (mdl_index >= last)
                    begin
                        mdl_index = last;
                        r = key_value(last);
                    end
                    else
                    begin
                        sum = longint'(mdl_total) + longint'(it.elapsed_ms);
                        mdl_total = (sum > 64'sd16777215) ? TIME_MAX : sum[TIME_W-1:0];
                        if (mdl_total >= mdl_time[mdl_index + 1])
                        begin
                            mdl_index++;
                        end
                        if (mdl_index == last)
                        begin
                            r = key_value(last);
                        end
                        else if (mdl_time[mdl_index + 1] == mdl_time[mdl_index])
                        begin
                            r = key_value(mdl_index + 1);
                        end
                        else
                        begin
                            p = mdl_index;
                            r.x = lerp_axis(mdl_x[p], mdl_x[p + 1],
                                longint'(mdl_total) - longint'(mdl_time[p]),
                                longint'(mdl_time[p + 1]) - longint'(mdl_time[p]));
                            r.y = lerp_axis(mdl_y[p], mdl_y[p + 1],
                                longint'(mdl_total) - longint'(mdl_time[p]),
                                longint'(mdl_time[p + 1]) - longint'(mdl_time[p]));
                            r.z = lerp_axis(mdl_z[p], mdl_z[p + 1],
                                longint'(mdl_total) - longint'(mdl_time[p]),
                                longint'(mdl_time[p + 1]) - longint'(mdl_time[p]));
                        end
                    end
                end
            end
            FUNC_INSERT:
            begin
                if (mdl_count >= NUM_KEYS)
                begin
                    r.status = STAT_FULL;
                end
                else
                begin
                    p = 0;
                    while (p < mdl_count && it.key.t_ms > mdl_time[p])
                    begin
                        p++;
                    end
                    for (int i = int'(mdl_count); i > int'(p); i--)
                    begin
                        mdl_time[i] = mdl_time[i - 1];
                        mdl_x[i] = mdl_x[i - 1];
                        mdl_y[i] = mdl_y[i - 1];
                        mdl_z[i] = mdl_z[i - 1];
                    end
                    mdl_time[p] = it.key.t_ms;
                    mdl_x[p] = it.key.x;
                    mdl_y[p] = it.key.y;
                    mdl_z[p] = it.key.z;
                    if (mdl_count == 0)
                    begin
                        mdl_index = 0;
                    end
                    else if (p <= mdl_index)
                    begin
                        mdl_index++;
                    end
                    mdl_count++;
                end
            end
            FUNC_REMOVE:
            begin
                pos = find_pos(it);
                if (pos < 0)
                begin
                    r.status = STAT_NOT_FOUND;
                end
                else
                begin
                    for (int i = pos; i + 1 < int'(mdl_count); i++)
                    begin
                        mdl_time[i] = mdl_time[i + 1];
                        mdl_x[i] = mdl_x[i + 1];
                        mdl_y[i] = mdl_y[i + 1];
                        mdl_z[i] = mdl_z[i + 1];
                    end
                    mdl_count--;
                    if (pos < int'(mdl_index))
                    begin
                        mdl_index--;
                    end
                    if (mdl_count == 0)
                    begin
                        mdl_index = 0;
                    end
                    else if (mdl_index >= mdl_count)
                    begin
                        mdl_index = mdl_count - 1;
                    end
                end
            end
            FUNC_FIND:
            begin
                if (find_pos(it) < 0)
                begin
                    r.status = STAT_NOT_FOUND;
                end
            end
            FUNC_RESTART:
            begin
                mdl_index = 0;
                mdl_total = '0;
            end
            default:
            begin
            end
        endcase
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [VAL_W-1:0] got,
                                   input logic [VAL_W-1:0] want);
        $display("mismatch %s: got %h, expected %h at %0t", what, got, want, $time);
        error_count++;
    endtask

    task automatic send_item(input item_t it);
        while (($urandom_range(99, 0) < send_idle_pct))
        begin
            req.valid <= 1'b0;
            @(posedge clk);
        end
        req.valid <= 1'b1;
        req.func <= it.func;
        req.elapsed_ms <= it.elapsed_ms;
        req.key_time <= it.key.t_ms;
        req.key_x <= it.key.x;
        req.key_y <= it.key.y;
        req.key_z <= it.key.z;
        @(posedge clk);
        while (!req.ready)
        begin
            @(posedge clk);
        end
        expected_results[exp_tail] = predict_item(it);
        exp_tail++;
    endtask

    function automatic item_t make_item(input logic [FUNC_W-1:0] f,
                                        input logic [ELAP_W-1:0] e,
                                        input logic [TIME_W-1:0] t,
                                        input logic [VAL_W-1:0] x,
                                        input logic [VAL_W-1:0] y,
                                        input logic [VAL_W-1:0] z);
        item_t it;
        it.func = f;
        it.elapsed_ms = e;
        it.key.t_ms = t;
        it.key.x = x;
        it.key.y = y;
        it.key.z = z;
        return it;
    endfunction

    function automatic logic [VAL_W-1:0] rand_value();
        case ($urandom_range(3, 0))
            0: return VAL_W'(24'h7FFFFF - $urandom_range(3, 0));
            1: return VAL_W'(24'h800000 + $urandom_range(3, 0));
            default: return VAL_W'($urandom());
        endcase
    endfunction

    // Keys that exist in the table are often reused so that most removes and finds hit.
    function automatic item_t random_item(input int insert_weight);
        item_t it;
        int unsigned k;
        int unsigned sel;
        sel = $urandom_range(99, 0);
        it = make_item(FUNC_TICK, ELAP_W'($urandom_range(3000, 0)),
                       TIME_W'($urandom_range(20000, 0)),
                       rand_value(), rand_value(), rand_value());
        if ($urandom_range(19, 0) == 0)
        begin
            it.elapsed_ms = ELAP_W'($urandom());
            it.key.t_ms = TIME_W'($urandom());
        end
        if (sel < insert_weight)
        begin
            it.func = FUNC_INSERT;
            if (mdl_count > 0 && $urandom_range(4, 0) == 0)
            begin
                it.key.t_ms = mdl_time[$urandom_range(mdl_count - 1, 0)];
            end
        end
        else if (sel < insert_weight + 12 || sel < insert_weight + 20)
        begin
            it.func = (sel < insert_weight + 12) ? FUNC_REMOVE : FUNC_FIND;
            if (mdl_count > 0 && $urandom_range(3, 0) != 0)
            begin
                k = $urandom_range(mdl_count - 1, 0);
                it.key.t_ms = mdl_time[k];
                it.key.x = mdl_x[k];
                it.key.y = mdl_y[k];
                it.key.z = mdl_z[k];
                if ($urandom_range(5, 0) == 0)
                begin
                    it.key.z[0] = ~it.key.z[0];
                end
            end
        end
        else if (sel < insert_weight + 24)
        begin
            it.func = FUNC_RESTART;
        end
        else if (sel < insert_weight + 26)
        begin
            it.func = FUNC_W'($urandom_range(FUNC_UNUSED_HI, FUNC_UNUSED_LO));
        end
        return it;
    endfunction

    task automatic test_directed();
        send_item(make_item(FUNC_TICK, 16'hFFFF, '0, '0, '0, '0));
        send_item(make_item(FUNC_FIND, '0, '0, '0, '0, '0));
        send_item(make_item(FUNC_REMOVE, '0, 24'hFFFFFF, '0, '0, '0));
        send_item(make_item(FUNC_INSERT, '0, 24'd100, 24'h7FFFFF, 24'h800000, '0));
        send_item(make_item(FUNC_TICK, 16'd50, '0, '0, '0, '0));
        send_item(make_item(FUNC_INSERT, '0, 24'd100, 24'h800000, 24'h7FFFFF, 24'h010000));
        send_item(make_item(FUNC_INSERT, '0, '0, 24'h123456, 24'hFEDCBA, 24'h000001));
        send_item(make_item(FUNC_INSERT, '0, 24'hFFFFFF, 24'h7FFFFF, 24'h7FFFFF, 24'h800000));
        send_item(make_item(FUNC_RESTART, '0, '0, '0, '0, '0));
        send_item(make_item(FUNC_TICK, 16'd30, '0, '0, '0, '0));
        send_item(make_item(FUNC_TICK, 16'd80, '0, '0, '0, '0));
        send_item(make_item(FUNC_TICK, 16'hFFFF, '0, '0, '0, '0));
        send_item(make_item(FUNC_TICK, 16'hFFFF, '0, '0, '0, '0));
        send_item(make_item(FUNC_FIND, '0, 24'd100, 24'h800000, 24'h7FFFFF, 24'h010000));
        send_item(make_item(FUNC_REMOVE, '0, 24'd100, 24'h7FFFFF, 24'h800000, '0));
        send_item(make_item(FUNC_REMOVE, '0, 24'd100, 24'h7FFFFF, 24'h800000, '0));
        send_item(make_item(FUNC_W'(FUNC_UNUSED_HI), 16'hFFFF, 24'hFFFFFF, 24'hFFFFFF,
                            24'hFFFFFF, 24'hFFFFFF));
        send_item(make_item(FUNC_RESTART, '0, '0, '0, '0, '0));
        for (int i = 0; i < 14; i++)
        begin
            send_item(make_item(FUNC_INSERT, '0, 24'hFFFFFF, VAL_W'(i), VAL_W'(-i),
                                VAL_W'(i)));
        end
        send_item(make_item(FUNC_INSERT, '0, 24'd5, 24'd1, 24'd2, 24'd3));
        while (mdl_count > 0)
        begin
            send_item(make_item(FUNC_REMOVE, '0, mdl_time[0], mdl_x[0], mdl_y[0], mdl_z[0]));
        end
    endtask

    task automatic test_random(input int count);
        int insert_weight;
        for (int i = 0; i < count; i++)
        begin
            insert_weight = (mdl_count < 4) ? 40 : ((mdl_count > 13) ? 8 : 20);
            send_item(random_item(insert_weight));
        end
    endtask

    always @(posedge clk)
    begin
        res_t want;
        if (rst_n)
        begin
            rsp.ready <= ($urandom_range(99, 0) >= recv_idle_pct);
            if (rsp.valid && rsp.ready)
            begin
                if (exp_head == exp_tail)
                begin
                    report_mismatch("unexpected item", rsp.value_x, '0);
                end
                else
                begin
                    want = expected_results[exp_head];
                    expected_results.delete(exp_head);
                    exp_head++;
                    if (rsp.value_x !== want.x)
                    begin
                        report_mismatch("value_x", rsp.value_x, want.x);
                    end
                    if (rsp.value_y !== want.y)
                    begin
                        report_mismatch("value_y", rsp.value_y, want.y);
                    end
                    if (rsp.value_z !== want.z)
                    begin
                        report_mismatch("value_z", rsp.value_z, want.z);
                    end
                    if (rsp.status !== want.status)
                    begin
                        report_mismatch("status", VAL_W'(rsp.status), VAL_W'(want.status));
                    end
                end
            end
            if ((req.valid && req.ready) || (rsp.valid && rsp.ready))
            begin
                quiet_cycles <= 0;
            end
            else
            begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    always @(posedge clk)
    begin
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    initial
    begin
        error_count = 0;
        quiet_cycles = 0;
        exp_head = 0;
        exp_tail = 0;
        mdl_count = 0;
        mdl_index = 0;
        mdl_total = '0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        rst_n = 1'b0;
        req.valid = 1'b0;
        req.func = FUNC_TICK;
        req.elapsed_ms = '0;
        req.key_time = '0;
        req.key_x = '0;
        req.key_y = '0;
        req.key_z = '0;
        rsp.ready = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        send_idle_pct = 11;
        recv_idle_pct = 56;
        test_directed();
        test_random(250);
        send_idle_pct = 56;
        recv_idle_pct = 11;
        test_random(250);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random(250);
        req.valid <= 1'b0;
        while (exp_head != exp_tail)
        begin
            @(posedge clk);
        end
        repeat (100) @(posedge clk);
        if (error_count == 0)
        begin
            $display("tb: success");
        end
        else
        begin
            $display("tb: failure");
        end
        $finish;
    end
endmodule

### sim.f
design/kfi_pkg.sv
design/kfi_req_if.sv
design/kfi_rsp_if.sv
design/kfi_cell.sv
design/kfi_lerp.sv
design/keyframe_linear_interpolator.sv
verif/keyframe_linear_interpolator_tb.sv
